>>> hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define EGC_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("egc: assertion failed");

// Concurrent assertion that is checked at every edge, reset included.
`define EGC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("egc: assertion failed");

`endif

>>> hw/rtl/egc_pkg.sv
// Shared widths, selector codes and reset values of the envelope generator converter.
package egc_pkg;

  localparam int REQ_TYPE_W   = 4;
  localparam int GEN_VALUE_W  = 16;
  localparam int REG_CODE_W   = 8;
  localparam int ATTACK_MAX_W = 7;

  localparam logic [ATTACK_MAX_W-1:0] ATTACK_MAX_RESET = 7'd120;

  // Conversion selector codes.
  localparam logic [REQ_TYPE_W-1:0] REQ_ATTACK     = 4'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_HOLD       = 4'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_DECAY      = 4'd2;
  localparam logic [REQ_TYPE_W-1:0] REQ_SUSTAIN    = 4'd3;
  localparam logic [REQ_TYPE_W-1:0] REQ_MOD_PITCH  = 4'd4;
  localparam logic [REQ_TYPE_W-1:0] REQ_MOD_CUTOFF = 4'd5;
  localparam logic [REQ_TYPE_W-1:0] REQ_CUTOFF     = 4'd6;
  localparam logic [REQ_TYPE_W-1:0] REQ_ATTEN      = 4'd7;
  localparam logic [REQ_TYPE_W-1:0] REQ_Q          = 4'd8;
  localparam logic [REQ_TYPE_W-1:0] REQ_PAN        = 4'd9;

  typedef logic [REQ_TYPE_W-1:0]          req_type_t;
  typedef logic signed [GEN_VALUE_W-1:0]  gen_value_t;
  typedef logic [REG_CODE_W-1:0]          reg_code_t;
  typedef logic [ATTACK_MAX_W-1:0]        attack_max_t;

endpackage

>>> hw/rtl/egc_if.sv
// Valid/ready stream interfaces for the request and result channels.
interface egc_req_if;
  logic                  valid;
  logic                  ready;
  egc_pkg::req_type_t    req_type;
  egc_pkg::gen_value_t   gen_value;

  modport source (output valid, output req_type, output gen_value, input ready);
  modport sink   (input valid, input req_type, input gen_value, output ready);
endinterface

interface egc_rsp_if;
  logic                  valid;
  logic                  ready;
  egc_pkg::reg_code_t    reg_code;

  modport source (output valid, output reg_code, input ready);
  modport sink   (input valid, input reg_code, output ready);
endinterface

>>> hw/rtl/egc_conv.sv
// Combinational conversion of one clamped generator value into a register code.
module egc_conv (
  input  egc_pkg::req_type_t    req_type,
  input  egc_pkg::gen_value_t   gen_value,
  input  egc_pkg::attack_max_t  attack_max,
  output egc_pkg::reg_code_t    reg_code
);

  function automatic logic signed [15:0] clamp16(input logic signed [15:0] v,
                                                 input logic signed [15:0] lo,
                                                 input logic signed [15:0] hi);
    logic signed [15:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  // Exact floor(n / 75) for n below 14174, by reciprocal multiplication.
  function automatic logic [7:0] div75(input logic [13:0] n);
    logic [27:0] p;
    p = {14'd0, n} * 28'd13982;
    return p[27:20];
  endfunction

  // Exact floor(n / 150) for n below 4800.
  function automatic logic [4:0] div150(input logic [12:0] n);
    logic [25:0] p;
    p = {13'd0, n} * 26'd6991;
    return p[24:20];
  endfunction

  logic signed [15:0] v_tc, v_cb, v_sh, v_cut, v_q, v_pan;

  // Attack
  logic signed [16:0] atk_sum, atk_slow_n;
  logic [12:0]        atk_n;
  logic [4:0]         atk_a;
  logic [3:0]         atk_fast;
  logic [7:0]         atk_slow_q;
  logic [8:0]         atk_slow_sum;
  logic [6:0]         atk_r, atk_code;

  // Hold
  logic signed [16:0] hld_x;
  logic [39:0]        hld_p;
  logic [18:0]        hld_h;
  logic [4:0]         hld_sh;
  logic [16:0]        hld_t, hld_ts;
  logic [6:0]         hld_code;

  // Decay
  logic signed [16:0] dec_fast_n, dec_slow_n;
  logic [4:0]         dec_d;
  logic [3:0]         dec_fast;
  logic [13:0]        dec_mag;
  logic [7:0]         dec_q;
  logic signed [9:0]  dec_sum;
  logic [6:0]         dec_code;

  // Sustain
  logic [10:0]        sus_cb;
  logic [32:0]        sus_p;
  logic [7:0]         sus_q;
  logic [6:0]         sus_code;

  // Modulation shifts
  logic               sh_neg;
  logic [13:0]        sh_m;
  logic [31:0]        shp_p;
  logic [10:0]        shp_q;
  logic [30:0]        shc_p;
  logic [7:0]         shc_q;
  logic [7:0]         shp_code, shc_code;

  // Cutoff
  logic [13:0]        cut_n;
  logic [29:0]        cut_p;
  logic [8:0]         cut_q;
  logic [8:0]         cut_d;
  logic [7:0]         cut_code;

  // Attenuation
  logic [10:0]        att_n;
  logic [22:0]        att_p;
  logic [5:0]         att_q;
  logic [13:0]        att_m;
  logic [7:0]         att_code;

  // Resonance
  logic [15:0]        q_p;
  logic [6:0]         q_q;
  logic [3:0]         q_code;

  // Pan
  logic [9:0]         pan_m;
  logic [28:0]        pan_p;
  logic [7:0]         pan_code;

  always_comb begin
    v_tc  = clamp16(gen_value, -16'sd12000, 16'sd5000);
    v_cb  = clamp16(gen_value, 16'sd0, 16'sd1440);
    v_sh  = clamp16(gen_value, -16'sd12000, 16'sd12000);
    v_cut = clamp16(gen_value, 16'sd1500, 16'sd13500);
    v_q   = clamp16(gen_value, 16'sd0, 16'sd960);
    v_pan = clamp16(gen_value, -16'sd500, 16'sd500);
  end

  // Attack: long times use a mantissa/shift code, short times a linear scale.
  always_comb begin
    atk_sum      = {v_tc[15], v_tc} + 17'sd500;
    atk_n        = atk_sum[16] ? 13'd0 : atk_sum[12:0];
    atk_a        = div150(atk_n);
    atk_fast     = {1'b1, ~atk_a[2:0]} >> atk_a[4:3];
    atk_slow_n   = 17'sd37 - {v_tc[15], v_tc};
    atk_slow_q   = div75(atk_slow_n[13:0]);
    atk_slow_sum = {1'b0, atk_slow_q} + 9'd8;
    if (v_tc >= 16'sd4300) begin
      atk_r = 7'd1;
    end else if (v_tc > -16'sd600) begin
      atk_r = {3'd0, atk_fast};
    end else if (atk_slow_sum > 9'd127) begin
      atk_r = 7'd127;
    end else begin
      atk_r = atk_slow_sum[6:0];
    end
    atk_code = (atk_r > attack_max) ? attack_max : atk_r;
  end

  // Hold: h = x * 65536 / 1200 with x = tc + 4130, then a 17-bit mantissa shift.
  always_comb begin
    hld_x  = {v_tc[15], v_tc} + 17'sd4130;
    hld_p  = {26'd0, hld_x[13:0]} * 40'd57266231;
    hld_h  = hld_p[38:20];
    hld_sh = 5'd16 - {2'd0, hld_h[18:16]};
    hld_t  = {1'b1, hld_h[15:0]};
    hld_ts = hld_t >> hld_sh;
    if (v_tc < -16'sd5368) begin
      hld_code = 7'd127;
    end else if (hld_x[16]) begin
      hld_code = 7'd0;
    end else if (hld_ts > 17'd127) begin
      hld_code = 7'd0;
    end else begin
      hld_code = 7'd127 - hld_ts[6:0];
    end
  end

  // Decay and release; the linear branch may see a negative numerator.
  always_comb begin
    dec_fast_n = {v_tc[15], v_tc} - 17'sd1800;
    dec_d      = div150(dec_fast_n[12:0]);
    dec_fast   = {1'b1, ~dec_d[2:0]} >> dec_d[4:3];
    dec_slow_n = 17'sd37 - {v_tc[15], v_tc};
    dec_mag    = dec_slow_n[16] ? 14'(-dec_slow_n) : dec_slow_n[13:0];
    dec_q      = div75(dec_mag);
    dec_sum    = dec_slow_n[16] ? (10'sd39 - $signed({2'd0, dec_q}))
                                : (10'sd39 + $signed({2'd0, dec_q}));
    if (v_tc > 16'sd1800) begin
      dec_code = {3'd0, dec_fast};
    end else if (dec_sum > 10'sd127) begin
      dec_code = 7'd127;
    end else begin
      dec_code = dec_sum[6:0];
    end
  end

  // Sustain: 127 - cb * 127 / 1000 in one reciprocal multiply, floor of 1.
  always_comb begin
    sus_cb = v_cb[10:0];
    sus_p  = {22'd0, sus_cb} * 33'd2130707;
    sus_q  = sus_p[31:24];
    if (sus_cb == 11'd0) begin
      sus_code = 7'd127;
    end else if (sus_q >= 8'd126) begin
      sus_code = 7'd1;
    end else begin
      sus_code = 7'd127 - sus_q[6:0];
    end
  end

  // Modulation shifts: divide the magnitude and saturate to a signed byte.
  always_comb begin
    sh_neg = v_sh[15];
    sh_m   = sh_neg ? 14'(-v_sh) : v_sh[13:0];
    shp_p  = {18'd0, sh_m} * 32'd223697;
    shp_q  = shp_p[31:21];
    shc_p  = {17'd0, sh_m} * 31'd74566;
    shc_q  = shc_p[29:22];
    if (sh_neg) begin
      shp_code = (shp_q >= 11'd128) ? 8'h80 : 8'(-shp_q[7:0]);
      shc_code = (shc_q >= 8'd128) ? 8'h80 : 8'(-shc_q);
    end else begin
      shp_code = (shp_q >= 11'd127) ? 8'h7F : shp_q[7:0];
      shc_code = (shc_q >= 8'd127) ? 8'h7F : shc_q;
    end
  end

  // Absolute cutoff.
  always_comb begin
    cut_n = v_cut[13:0] + 14'd15;
    cut_p = {16'd0, cut_n} * 30'd36158;
    cut_q = cut_p[28:20];
    cut_d = cut_q - 9'd153;
    if (cut_q < 9'd153) begin
      cut_code = 8'd0;
    end else if (cut_d > 9'd255) begin
      cut_code = 8'd255;
    end else begin
      cut_code = cut_d[7:0];
    end
  end

  // Attenuation: ((cb + 12) / 24) * 8 / 3, the last step as 2q + 2q/3.
  always_comb begin
    att_n    = v_cb[10:0] + 11'd12;
    att_p    = {12'd0, att_n} * 23'd2731;
    att_q    = att_p[21:16];
    att_m    = {8'd0, att_q} * 14'd171;
    att_code = {1'b0, att_q, 1'b0} + {2'd0, att_m[13:8]};
  end

  // Resonance nibble: cb / 12 as (cb / 4) / 3.
  always_comb begin
    q_p    = {8'd0, v_q[9:2]} * 16'd171;
    q_q    = q_p[15:9];
    q_code = (q_q > 7'd15) ? 4'd15 : q_q[3:0];
  end

  // Pan: (500 - p) * 255 / 1000 folded into one reciprocal multiply.
  always_comb begin
    pan_m    = 10'(16'sd500 - v_pan);
    pan_p    = {19'd0, pan_m} * 29'd267387;
    pan_code = pan_p[27:20];
  end

  always_comb begin
    case (req_type)
      egc_pkg::REQ_ATTACK:     reg_code = {1'b0, atk_code};
      egc_pkg::REQ_HOLD:       reg_code = {1'b0, hld_code};
      egc_pkg::REQ_DECAY:      reg_code = {1'b0, dec_code};
      egc_pkg::REQ_SUSTAIN:    reg_code = {1'b0, sus_code};
      egc_pkg::REQ_MOD_PITCH:  reg_code = shp_code;
      egc_pkg::REQ_MOD_CUTOFF: reg_code = shc_code;
      egc_pkg::REQ_CUTOFF:     reg_code = cut_code;
      egc_pkg::REQ_ATTEN:      reg_code = att_code;
      egc_pkg::REQ_Q:          reg_code = {4'd0, q_code};
      egc_pkg::REQ_PAN:        reg_code = pan_code;
      default:                 reg_code = '0;
    endcase
  end

endmodule

>>> hw/rtl/envelope_generator_converter.sv
// Top level of the envelope generator converter: input stage, conversion, result register.
//
//   channel  | direction | beat contents
//   ---------+-----------+--------------------------------------
//   in_req   | sink      | req_type, gen_value
//   out_rsp  | source    | reg_code
//   cfg      | write     | attack_max (cfg_we, cfg_wdata)
//
// Every beat passes from acceptance into the input stage register, then through the
// conversion logic into the result register. A new beat is accepted in every cycle unless
// the input stage stalls; sustained rate is one beat per cycle while out_rsp is ready.
// The two stages stall together only when the result register is full and out_rsp
// is not ready; the input stage still accepts while it is empty.
// Reset empties both stages and sets attack_max to 120.
module envelope_generator_converter (
  input  logic                  clk,
  input  logic                  rst_n,
  egc_req_if.sink               in_req,
  egc_rsp_if.source             out_rsp,
  input  logic                  cfg_we,
  input  egc_pkg::attack_max_t  cfg_wdata
);

  logic                  s1_valid_r, s1_valid_nxt;
  egc_pkg::req_type_t    s1_type_r;
  egc_pkg::gen_value_t   s1_value_r;
  logic                  out_valid_r, out_valid_nxt;
  egc_pkg::reg_code_t    out_code_r;
  egc_pkg::reg_code_t    conv_code;
  egc_pkg::attack_max_t  attack_max_r, attack_max_nxt;
  logic                  out_free;
  logic                  s1_free;
  logic                  in_fire;
  logic                  s1_move;

  assign out_free = !out_valid_r || out_rsp.ready;
  assign s1_free  = !s1_valid_r || out_free;
  assign in_fire  = in_req.valid && s1_free;
  assign s1_move  = s1_valid_r && out_free;

  assign in_req.ready     = s1_free;
  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.reg_code = out_code_r;

  always_comb begin
    s1_valid_nxt   = s1_free ? in_req.valid : s1_valid_r;
    out_valid_nxt  = out_free ? s1_valid_r : out_valid_r;
    attack_max_nxt = attack_max_r;
    if (cfg_we) begin
      // A zero limit would block every attack; it is stored as one.
      attack_max_nxt = (cfg_wdata == '0) ? egc_pkg::attack_max_t'(1) : cfg_wdata;
    end
  end

  egc_conv u_conv (
    .req_type   (s1_type_r),
    .gen_value  (s1_value_r),
    .attack_max (attack_max_r),
    .reg_code   (conv_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      attack_max_r <= egc_pkg::ATTACK_MAX_RESET;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      attack_max_r <= attack_max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_type_r  <= in_req.req_type;
      s1_value_r <= in_req.gen_value;
    end
    if (s1_move) begin
      out_code_r <= conv_code;
    end
  end

endmodule

>>> hw/rtl/egc_checker.sv
// Port-level checker for the envelope generator converter and its bind.
`include "assert_macros.svh"

module egc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input egc_pkg::reg_code_t  out_code
);

  logic in_fire;

  assign in_fire = in_valid && in_ready;

  // A stalled result beat keeps its value.
  `EGC_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_code))

  // Reset leaves no result pending and the input open.
  `EGC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid && in_ready)

  // An empty result register never blocks the input stage.
  `EGC_ASSERT_RST(a_no_false_stall, clk, rst_n, !out_valid |-> in_ready)

  // An accepted beat passes through the input stage into the result register when out_ready lets it drain.
  `EGC_ASSERT_RST(a_latency, clk, rst_n, in_fire ##1 out_ready |=> out_valid)

endmodule

bind envelope_generator_converter egc_checker u_egc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_code  (out_rsp.reg_code)
);

>>> dv/egc_result_checker.sv
// Result checker for the envelope generator converter: predicts each register code and compares.
module egc_result_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  egc_req_if                    req,
  egc_rsp_if                    rsp,
  input  logic                  cfg_we,
  input  egc_pkg::attack_max_t  cfg_wdata,
  output int                    mismatches,
  output int                    codes_checked,
  output int                    outstanding
);

  typedef struct {
    egc_pkg::req_type_t  sel;
    egc_pkg::gen_value_t amount;
    egc_pkg::reg_code_t  code;
  } pending_code_t;

  pending_code_t expected_codes [$];
  pending_code_t oldest;
  int            attack_limit = int'(egc_pkg::ATTACK_MAX_RESET);
  int            fail_tally = 0;
  int            checked_tally = 0;

  assign mismatches    = fail_tally;
  assign codes_checked = checked_tally;

  function automatic int limit_to(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Register code for one generator amount; every division truncates toward zero.
  function automatic egc_pkg::reg_code_t convert_generator(egc_pkg::req_type_t sel,
                                                           egc_pkg::gen_value_t amount,
                                                           int amax);
    int     v;
    int     r;
    int     a;
    int     sh;
    longint x;
    longint h;
    longint t;
    v = amount;
    r = 0;
    case (sel)
      egc_pkg::REQ_ATTACK: begin
        v = limit_to(v, -12000, 5000);
        if (v >= 4300) begin
          r = 1;
        end else begin
          if (v > -600) begin
            a = (v + 500) / 150;
            if (a < 0) a = 0;
            r = ((~a) & 7) | 8;
            r = r >> (a >> 3);
            if (r < 1) r = 1;
          end else begin
            r = (37 - v) / 75 + 8;
            if (r > 127) r = 127;
          end
          if (r > amax) r = amax;
        end
      end
      egc_pkg::REQ_HOLD: begin
        v = limit_to(v, -12000, 5000);
        x = longint'(v) + 4130;
        if (v < -5368) begin
          r = 127;
        end else if (x < 0) begin
          r = 0;
        end else begin
          h = (x * 65536) / 1200;
          t = 65536 | (h & 65535);
          sh = 16 - int'((h >>> 16) & 255);
          if (sh < 0) sh = 0;
          if (sh > 31) begin
            r = 127;
          end else begin
            t = t >> sh;
            t = 127 - t;
            if (t < 0) t = 0;
            if (t > 127) t = 127;
            r = int'(t);
          end
        end
      end
      egc_pkg::REQ_DECAY: begin
        v = limit_to(v, -12000, 5000);
        if (v > 1800) begin
          a = (v - 1800) / 150;
          r = ((~a) & 7) | 8;
          if ((a >> 3) > 15) r = 1;
          else r = r >> (a >> 3);
          if (r < 1) r = 1;
        end else begin
          r = (37 - v) / 75 + 39;
          if (r > 127) r = 127;
        end
      end
      egc_pkg::REQ_SUSTAIN: begin
        v = limit_to(v, 0, 1440);
        if (v <= 0) r = 127;
        else r = limit_to(127 - (v * 127) / 1000, 1, 127);
      end
      egc_pkg::REQ_MOD_PITCH, egc_pkg::REQ_MOD_CUTOFF: begin
        v = limit_to(v, -12000, 12000);
        r = limit_to((v * 128) / ((sel == egc_pkg::REQ_MOD_PITCH) ? 1200 : 7200),
                     -128, 127);
        if (r < 0) r = 256 + r;
      end
      egc_pkg::REQ_CUTOFF: begin
        v = limit_to(v, 1500, 13500);
        r = limit_to((v + 15) / 29 - 153, 0, 255);
      end
      egc_pkg::REQ_ATTEN: begin
        v = limit_to(v, 0, 1440);
        r = ((v + 12) / 24) * 8 / 3;
        if (r > 255) r = 255;
      end
      egc_pkg::REQ_Q: begin
        v = limit_to(v, 0, 960);
        r = limit_to(v / 12, 0, 15);
      end
      egc_pkg::REQ_PAN: begin
        v = limit_to(v, -500, 500);
        r = limit_to(((500 - v) * 255) / 1000, 0, 255);
      end
      default: r = 0;
    endcase
    return egc_pkg::reg_code_t'(r);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] egc mismatch: %s", $time, msg);
    fail_tally++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_codes.delete();
      attack_limit = int'(egc_pkg::ATTACK_MAX_RESET);
      outstanding <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        checked_tally++;
        if (expected_codes.size() == 0) begin
          report_mismatch($sformatf("result 0x%02h with no request pending", rsp.reg_code));
        end else begin
          oldest = expected_codes.pop_front();
          if (rsp.reg_code !== oldest.code)
            report_mismatch($sformatf("type %0d amount %0d: reg_code 0x%02h, wanted 0x%02h",
                                      oldest.sel, oldest.amount, rsp.reg_code, oldest.code));
        end
      end
      if (req.valid && req.ready)
        expected_codes.push_back('{req.req_type, req.gen_value,
                                   convert_generator(req.req_type, req.gen_value,
                                                     attack_limit)});
      // A write of zero is stored as one.
      if (cfg_we) attack_limit = (cfg_wdata == '0) ? 1 : int'(cfg_wdata);
      outstanding <= expected_codes.size();
    end
  end

endmodule

>>> dv/tb_envelope_generator_converter.sv
// Testbench top for the envelope generator converter: clock, reset, stimulus and verdict.
module tb_envelope_generator_converter;

  localparam int                 CYCLE_LIMIT      = 200000;
  localparam int                 RANDOM_PER_PHASE = 108;
  localparam int                 PHASE_COUNT      = 6;
  localparam int                 DIRECTED_COUNT   = 22;
  localparam egc_pkg::req_type_t REQ_UNUSED_LO    = 4'd10;
  localparam egc_pkg::req_type_t REQ_UNUSED_HI    = 4'd15;

  localparam egc_pkg::req_type_t DIRECTED_SEL [DIRECTED_COUNT] = '{
    egc_pkg::REQ_ATTACK, egc_pkg::REQ_ATTACK, egc_pkg::REQ_ATTACK, egc_pkg::REQ_ATTACK,
    egc_pkg::REQ_HOLD, egc_pkg::REQ_HOLD, egc_pkg::REQ_HOLD, egc_pkg::REQ_HOLD,
    egc_pkg::REQ_DECAY, egc_pkg::REQ_DECAY, egc_pkg::REQ_DECAY,
    egc_pkg::REQ_SUSTAIN, egc_pkg::REQ_SUSTAIN,
    egc_pkg::REQ_MOD_PITCH, egc_pkg::REQ_MOD_CUTOFF,
    egc_pkg::REQ_CUTOFF, egc_pkg::REQ_ATTEN, egc_pkg::REQ_Q,
    egc_pkg::REQ_PAN, egc_pkg::REQ_PAN,
    REQ_UNUSED_HI, REQ_UNUSED_LO
  };
  localparam int DIRECTED_VAL [DIRECTED_COUNT] = '{
    -32768, 32767, -600, 4299,
    -5369, -5368, -4131, 5000,
    1800, 32767, -12000,
    0, 1440,
    -32768, 32767,
    0, 1440, 960, -500, 500,
    -1, 0
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  egc_pkg::attack_max_t cfg_wdata;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int settings_used  = 1;
  int random_sent    = 0;
  int mismatches;
  int codes_checked;
  int outstanding;

  egc_req_if in_req ();
  egc_rsp_if out_rsp ();

  envelope_generator_converter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  egc_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (in_req),
    .rsp           (out_rsp),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .codes_checked (codes_checked),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles with %0d results outstanding", CYCLE_LIMIT, outstanding);
    $display("FAIL");
    $finish;
  end

  initial begin
    out_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_rsp.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_request(egc_pkg::req_type_t sel, egc_pkg::gen_value_t amount);
    while ($urandom_range(99) < src_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid     <= 1'b1;
    in_req.req_type  <= sel;
    in_req.gen_value <= amount;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
  endtask

  // Stops sending and waits for the last beat in flight to come back.
  task automatic drain_results();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_attack_max(egc_pkg::attack_max_t value);
    drain_results();
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // Mostly amounts inside the clamp range of the chosen conversion, some near its knees.
  function automatic egc_pkg::gen_value_t pick_gen_value(egc_pkg::req_type_t sel);
    int lo;
    int hi;
    int knee;
    int mode;
    lo = -32768;
    hi = 32767;
    knee = 0;
    case (sel)
      egc_pkg::REQ_ATTACK: begin
        lo = -12000; hi = 5000;
        knee = $urandom_range(1) ? 4300 : -600;
      end
      egc_pkg::REQ_HOLD: begin
        lo = -12000; hi = 5000;
        knee = $urandom_range(1) ? -5368 : -4130;
      end
      egc_pkg::REQ_DECAY:   begin lo = -12000; hi = 5000;  knee = 1800; end
      egc_pkg::REQ_SUSTAIN: begin lo = 0;      hi = 1440;  knee = 1000; end
      egc_pkg::REQ_ATTEN:   begin lo = 0;      hi = 1440;  knee = 12;   end
      egc_pkg::REQ_MOD_PITCH, egc_pkg::REQ_MOD_CUTOFF: begin
        lo = -12000; hi = 12000; knee = 0;
      end
      egc_pkg::REQ_CUTOFF:  begin lo = 1500;   hi = 13500; knee = 4451; end
      egc_pkg::REQ_Q:       begin lo = 0;      hi = 960;   knee = 180;  end
      egc_pkg::REQ_PAN:     begin lo = -500;   hi = 500;   knee = 0;    end
      default:              knee = 0;
    endcase
    mode = $urandom_range(9);
    if (mode < 3) return egc_pkg::gen_value_t'($urandom);
    if (mode < 9) return egc_pkg::gen_value_t'(lo + int'($urandom_range(hi - lo)));
    case ($urandom_range(6))
      0:       return egc_pkg::gen_value_t'(lo);
      1:       return egc_pkg::gen_value_t'(hi);
      2:       return egc_pkg::gen_value_t'(lo - 1);
      3:       return egc_pkg::gen_value_t'(hi + 1);
      4:       return egc_pkg::gen_value_t'(knee - 1);
      5:       return egc_pkg::gen_value_t'(knee + 1);
      default: return egc_pkg::gen_value_t'(knee);
    endcase
  endfunction

  initial begin
    egc_pkg::req_type_t sel;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_req.valid     <= 1'b0;
    in_req.req_type  <= egc_pkg::REQ_ATTACK;
    in_req.gen_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats run with the reset value of attack_max and no idling.
    for (int i = 0; i < DIRECTED_COUNT; i++)
      send_request(DIRECTED_SEL[i], egc_pkg::gen_value_t'(DIRECTED_VAL[i]));

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0:       write_attack_max(7'd127);
        1:       write_attack_max(7'd0);
        2:       write_attack_max(7'd1);
        default: write_attack_max(egc_pkg::attack_max_t'($urandom_range(126, 2)));
      endcase
      case (phase % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 88; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 88; end
        default: begin src_idle_pct = 23; sink_stall_pct = 23; end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if ($urandom_range(19) == 0)
          sel = REQ_UNUSED_LO
                + egc_pkg::req_type_t'($urandom_range(REQ_UNUSED_HI - REQ_UNUSED_LO));
        else
          sel = egc_pkg::req_type_t'($urandom_range(egc_pkg::REQ_PAN, egc_pkg::REQ_ATTACK));
        if ($urandom_range(99) == 0) drain_results();
        send_request(sel, pick_gen_value(sel));
        random_sent++;
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("Covered %0d directed and %0d random requests over %0d attack_max settings",
             DIRECTED_COUNT, random_sent, settings_used);
    $display("and four idle/stall mixes; %0d result codes compared, %0d mismatches.",
             codes_checked, mismatches);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
